>>> sv/lpi_pkg.sv
// Package for the layer palette indexer: word types, item kinds, color conversion.
`default_nettype none
package lpi_pkg;

  localparam int LPI_COLORS_PER_LAYER = 16;
  localparam int LPI_LAYER_LIMIT      = 16;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_STATUS = 2'd2
  } item_kind_t;

  typedef enum logic {
    ST_PIXEL,
    ST_DRAIN
  } lpi_state_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        layer_end;
  } lpi_in_t;

  typedef struct packed {
    item_kind_t  item_kind;
    logic [7:0]  palette_index;
    logic [15:0] palette_word;
    logic        color_overflow;
    logic        too_many_layers;
    logic        run_last;
  } lpi_out_t;

  // ARGB8888 -> alpha flag + BGR555
  function automatic logic [15:0] to_bgr555(input logic [31:0] px);
    return {px[31], px[7:3], px[15:11], px[23:19]};
  endfunction

endpackage
`default_nettype wire

>>> sv/layer_palette_indexer_unit.sv
// Top level of the layer palette indexer: slot chain, control and output register.
//
// Input channel (in_valid / in_stall / in_word) carries one ARGB pixel per word plus
// a layer_end flag. Result channel (out_valid / out_stall / out_word) carries pixel
// indices, palette entries and layer status words. cfg_wr_en / cfg_wr_data load the
// transparent key.
// Each pixel gives one result word in the cycle after acceptance; a new pixel can be
// accepted every cycle outside a layer-end drain and while out_stall is low, set by
// the row of parallel slot compares. A pixel with layer_end set is followed by one
// palette entry per used slot (none if the layer overflowed or is past the layer
// limit) and a status word. These drain out of the slot chain at one word per cycle
// while out_stall is low, and in_stall stays high for the whole drain, which
// lasts longer while out_stall is high.
// Reset (rst_n low, synchronous) empties the output register, clears the key,
// slot count, layer number and overflow flag.
// When out_stall is high the output register holds its word and in_stall follows,
// so no word is lost or repeated.
`default_nettype none
module layer_palette_indexer_unit
  import lpi_pkg::*;
#(
  parameter int COLORS_PER_LAYER = LPI_COLORS_PER_LAYER,
  parameter int LAYER_LIMIT      = LPI_LAYER_LIMIT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire lpi_in_t     in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output lpi_out_t         out_word
);

  localparam int UW = $clog2(COLORS_PER_LAYER + 1);
  localparam int IW = $clog2(COLORS_PER_LAYER);
  localparam int LW = $clog2(LAYER_LIMIT + 1);

  lpi_state_t  state_r, state_nxt;
  logic [31:0] key_r;
  logic [UW-1:0] used_r, used_nxt;
  logic [UW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] layer_r, layer_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  lpi_out_t    out_r, out_nxt;

  logic [31:0] colors [COLORS_PER_LAYER];
  logic [COLORS_PER_LAYER-1:0] hits;
  logic [IW-1:0] hit_idx;
  logic        wr_en;
  logic        shift_en;
  logic        out_free;
  logic        past;
  logic [7:0]  base;

  for (genvar g = 0; g < COLORS_PER_LAYER; g++) begin : g_cell
    localparam int NXT = (g == COLORS_PER_LAYER - 1) ? g : g + 1;
    lpi_cell u_cell (
      .clk        (clk),
      .cmp_value  (in_word.pixel_value),
      .live       (used_r > UW'(g)),
      .load_en    (wr_en && (used_r == UW'(g))),
      .load_value (in_word.pixel_value),
      .shift_en   (shift_en),
      .shift_in   (colors[NXT]),
      .color      (colors[g]),
      .hit        (hits[g])
    );
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < COLORS_PER_LAYER; i++) begin
      if (hits[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign past     = layer_r >= LW'(LAYER_LIMIT);
  assign base     = 8'(int'(layer_r) * COLORS_PER_LAYER);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    cnt_nxt       = cnt_r;
    layer_nxt     = layer_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    shift_en      = 1'b0;
    in_stall      = 1'b1;
    case (state_r)
      ST_PIXEL: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          out_nxt.item_kind     = KIND_PIXEL;
          out_nxt.palette_index = '0;
          out_nxt.palette_word  = '0;
          if (!past && (in_word.pixel_value != key_r)) begin
            if (|hits) begin
              out_nxt.palette_index = 8'(base + 8'(hit_idx));
            end else if (used_r < UW'(COLORS_PER_LAYER)) begin
              wr_en                 = 1'b1;
              out_nxt.palette_index = 8'(base + 8'(used_r));
              used_nxt              = used_r + UW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          out_nxt.color_overflow  = ovf_nxt;
          out_nxt.too_many_layers = past;
          out_nxt.run_last        = !in_word.layer_end;
          out_valid_nxt           = 1'b1;
          if (in_word.layer_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!ovf_r && (cnt_r < used_r)) begin
            shift_en                = 1'b1;
            out_nxt.item_kind       = KIND_ENTRY;
            out_nxt.palette_index   = 8'(base + 8'(cnt_r));
            out_nxt.palette_word    = to_bgr555(colors[0]);
            out_nxt.color_overflow  = 1'b0;
            out_nxt.too_many_layers = 1'b0;
            out_nxt.run_last        = 1'b0;
            cnt_nxt                 = cnt_r + UW'(1);
          end else begin
            out_nxt.item_kind       = KIND_STATUS;
            out_nxt.palette_index   = 8'(layer_r);
            out_nxt.palette_word    = '0;
            out_nxt.color_overflow  = ovf_r;
            out_nxt.too_many_layers = past;
            out_nxt.run_last        = 1'b1;
            used_nxt                = '0;
            ovf_nxt                 = 1'b0;
            if (!past) begin
              layer_nxt = layer_r + LW'(1);
            end
            state_nxt = ST_PIXEL;
          end
        end
      end
      default: begin
        state_nxt = ST_PIXEL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PIXEL;
      key_r       <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      layer_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      layer_r     <= layer_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        key_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

>>> sv/lpi_cell.sv
// One color slot of the palette chain: holds a color, compares it, shifts to its neighbor.
`default_nettype none
module lpi_cell
  import lpi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] cmp_value,
  input  wire logic        live,
  input  wire logic        load_en,
  input  wire logic [31:0] load_value,
  input  wire logic        shift_en,
  input  wire logic [31:0] shift_in,
  output logic      [31:0] color,
  output logic             hit
);

  logic [31:0] color_r;
  logic [31:0] color_nxt;

  always_comb begin
    color_nxt = color_r;
    if (load_en) begin
      color_nxt = load_value;
    end else if (shift_en) begin
      color_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
  end

  assign color = color_r;
  assign hit   = live && (color_r == cmp_value);

endmodule
`default_nettype wire
